/* design/utf8dw_pkg.sv */
// Shared types, constants and the codepoint column-width function for utf8_display_width.
package utf8dw_pkg;

  localparam int CNT_W = 32;
  localparam int OUT_W = 32;
  localparam int BYTE_W = 8;
  localparam int CP_W = 21;
  localparam int INC_W = 3;
  localparam int N_ZERO = 42;
  localparam int N_WIDE = 16;

  localparam logic [CP_W-1:0] CP_C0_END = 21'h00020;
  localparam logic [CP_W-1:0] CP_DEL = 21'h0007F;
  localparam logic [CP_W-1:0] CP_C1_LO = 21'h00080;
  localparam logic [CP_W-1:0] CP_C1_HI = 21'h0009F;
  localparam logic [CP_W-1:0] CP_SUR_LO = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SUR_HI = 21'h0DFFF;

  localparam logic [1:0] COLS_NONE = 2'd0;
  localparam logic [1:0] COLS_ONE = 2'd1;
  localparam logic [1:0] COLS_TWO = 2'd2;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } cp_range_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] total_width;
  } result_t;

  localparam cp_range_t ZERO_RANGES [N_ZERO] = '{
    '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00489}, '{21'h00591, 21'h005BD},
    '{21'h005BF, 21'h005BF}, '{21'h005C1, 21'h005C2}, '{21'h005C4, 21'h005C5},
    '{21'h005C7, 21'h005C7}, '{21'h00610, 21'h0061A}, '{21'h0064B, 21'h0065F},
    '{21'h00670, 21'h00670}, '{21'h006D6, 21'h006DC}, '{21'h006DF, 21'h006E4},
    '{21'h006E7, 21'h006E8}, '{21'h006EA, 21'h006ED}, '{21'h00711, 21'h00711},
    '{21'h00730, 21'h0074A}, '{21'h007A6, 21'h007B0}, '{21'h00816, 21'h00819},
    '{21'h0081B, 21'h00823}, '{21'h00825, 21'h00827}, '{21'h00829, 21'h0082D},
    '{21'h00859, 21'h0085B}, '{21'h00E31, 21'h00E31}, '{21'h00E34, 21'h00E3A},
    '{21'h00E47, 21'h00E4E}, '{21'h00EB1, 21'h00EB1}, '{21'h00EB4, 21'h00EB9},
    '{21'h00EBB, 21'h00EBC}, '{21'h00EC8, 21'h00ECD}, '{21'h0180B, 21'h0180D},
    '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF}, '{21'h0200B, 21'h0200F},
    '{21'h0202A, 21'h0202E}, '{21'h02060, 21'h02064}, '{21'h02066, 21'h0206F},
    '{21'h020D0, 21'h020FF}, '{21'h0302A, 21'h0302F}, '{21'h0FE00, 21'h0FE0F},
    '{21'h0FE20, 21'h0FE2F}, '{21'h0FEFF, 21'h0FEFF}, '{21'hE0100, 21'hE01EF}
  };

  localparam cp_range_t WIDE_RANGES [N_WIDE] = '{
    '{21'h01100, 21'h0115F}, '{21'h02E80, 21'h0303E}, '{21'h03041, 21'h033FF},
    '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF}, '{21'h0A000, 21'h0A4CF},
    '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF}, '{21'h0FE30, 21'h0FE4F},
    '{21'h0FF00, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6}, '{21'h1F300, 21'h1F64F},
    '{21'h1F680, 21'h1F6FF}, '{21'h1F900, 21'h1F9FF}, '{21'h20000, 21'h2FFFD},
    '{21'h30000, 21'h3FFFD}
  };

  function automatic logic [1:0] cols_of(input logic [CP_W-1:0] cp);
    logic hit_zero;
    logic hit_wide;
    logic [1:0] cols;
    hit_zero = 1'b0;
    hit_wide = 1'b0;
    for (int i = 0; i < N_ZERO; i++) begin
      if (cp >= ZERO_RANGES[i].lo && cp <= ZERO_RANGES[i].hi) hit_zero = 1'b1;
    end
    for (int i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_RANGES[i].lo && cp <= WIDE_RANGES[i].hi) hit_wide = 1'b1;
    end
    if (cp < CP_C0_END || cp == CP_DEL) cols = COLS_NONE;
    else if (cp >= CP_C1_LO && cp <= CP_C1_HI) cols = COLS_NONE;
    else if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) cols = COLS_NONE;
    else if (hit_zero) cols = COLS_NONE;
    else if (hit_wide) cols = COLS_TWO;
    else cols = COLS_ONE;
    return cols;
  endfunction

endpackage

/* design/utf8_display_width.sv */
// Top level of utf8_display_width: UTF-8 byte stream in, string display width out.
//
// Input channel: one byte of a UTF-8 string per transaction on in_text_byte,
// with in_end_of_text high on the string's final byte. Output channel: one
// transaction per string on out_total_width, the summed terminal columns,
// saturating at all ones. Both channels transfer when valid is high and stall
// is low.
// Throughput: one byte per cycle, also while a total waits, but a final byte
// waits while the result register is not free. Path: a final byte is held in
// the input register, then its total in the result register once that is free;
// decode, the range compares and the saturating add are done combinationally
// between the two registers.
// Stall: a stalled total is held in the result register. Bytes that are not
// final keep flowing; a final byte waits in the input register until the
// result register is free, and in_stall is raised only then.
// Reset: synchronous, active low; clears both registers' valid flags, the open
// sequence and the running total. No clearing pass follows.
module utf8_display_width
  import utf8dw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_total_width
);

  logic    take;
  logic    item_valid;
  item_t   item;
  logic    out_ready;
  result_t result;

  utf8dw_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .take           (take),
    .item_valid     (item_valid),
    .item           (item)
  );

  utf8dw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .take       (take),
    .result     (result)
  );

  utf8dw_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .result          (result),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_total_width (out_total_width)
  );

endmodule

/* design/utf8dw_in_stage.sv */
// Input register of utf8_display_width: holds one byte transaction for the decoder.
module utf8dw_in_stage
  import utf8dw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_end_of_text,
  input  logic              take,
  output logic              item_valid,
  output item_t             item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = valid_r && !take;
  assign load = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.text_byte <= in_text_byte;
      item_r.end_of_text <= in_end_of_text;
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

/* design/utf8dw_core.sv */
// UTF-8 decode state and saturating column accumulator of utf8_display_width.
module utf8dw_core
  import utf8dw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    out_ready,
  output logic    take,
  output result_t result
);

  localparam logic [CNT_W+OUT_W-1:0] OUT_CAP = (CNT_W+OUT_W)'({OUT_W{1'b1}});

  logic [CP_W-1:0]  pc_r, pc_nxt;
  logic [1:0]       need_r, need_nxt;
  logic [1:0]       held_r, held_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;

  logic [BYTE_W-1:0] b;
  logic              is_cont;
  logic              cont_path;
  logic              do_lead;
  logic [CP_W-1:0]   cp_full;
  logic [CP_W-1:0]   cols_in;
  logic [1:0]        cols;
  logic [INC_W-1:0]  inc;
  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  run_sat;
  logic [CNT_W+OUT_W-1:0] run_ext;

  assign b = item.text_byte;
  assign is_cont = (b[7:6] == 2'b10);
  assign cont_path = (need_r != 2'd0) && is_cont;
  assign do_lead = !cont_path;
  assign cp_full = {pc_r[CP_W-7:0], b[5:0]};
  assign cols_in = cont_path ? cp_full : {{(CP_W-BYTE_W){1'b0}}, b};
  assign cols = cols_of(cols_in);

  assign take = item_valid && (!item.end_of_text || out_ready);

  always_comb begin
    pc_nxt = pc_r;
    need_nxt = need_r;
    held_nxt = held_r;
    inc = '0;
    if (cont_path) begin
      pc_nxt = cp_full;
      need_nxt = need_r - 2'd1;
      held_nxt = held_r + 2'd1;
      if (need_r == 2'd1) begin
        inc = INC_W'(cols);
        held_nxt = 2'd0;
      end
    end else if (need_r != 2'd0) begin
      inc = INC_W'(held_r) + INC_W'(1);
      need_nxt = 2'd0;
    end
    if (do_lead) begin
      held_nxt = 2'd0;
      if (b inside {[8'h00:8'h7F]}) begin
        inc = inc + INC_W'(cols);
      end else if (b inside {[8'hC0:8'hDF]}) begin
        pc_nxt = CP_W'(b[4:0]);
        need_nxt = 2'd1;
      end else if (b inside {[8'hE0:8'hEF]}) begin
        pc_nxt = CP_W'(b[3:0]);
        need_nxt = 2'd2;
      end else if (b inside {[8'hF0:8'hF7]}) begin
        pc_nxt = CP_W'(b[2:0]);
        need_nxt = 2'd3;
      end else begin
        inc = inc + INC_W'(1);
      end
    end
    if (item.end_of_text && need_nxt != 2'd0) begin
      inc = inc + INC_W'(held_nxt) + INC_W'(1);
    end
    if (item.end_of_text) begin
      pc_nxt = '0;
      need_nxt = 2'd0;
      held_nxt = 2'd0;
    end
  end

  assign sum = {1'b0, run_r} + (CNT_W+1)'(inc);
  assign run_sat = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  assign run_ext = (CNT_W+OUT_W)'(run_sat);

  always_comb begin
    run_nxt = run_sat;
    if (item.end_of_text) begin
      run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      need_r <= 2'd0;
      held_r <= 2'd0;
      run_r <= '0;
    end else if (take) begin
      pc_r <= pc_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
      run_r <= run_nxt;
    end
  end

  always_comb begin
    result.valid = take && item.end_of_text;
    if (run_ext > OUT_CAP) result.total_width = {OUT_W{1'b1}};
    else result.total_width = run_ext[OUT_W-1:0];
  end

endmodule

/* design/utf8dw_out_stage.sv */
// Result register of utf8_display_width: holds the total until the receiver takes it.
module utf8dw_out_stage
  import utf8dw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  result_t          result,
  output logic             out_ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_total_width
);

  logic             valid_r;
  logic             valid_nxt;
  logic [OUT_W-1:0] width_r;

  assign out_ready = !valid_r || !out_stall;
  assign valid_nxt = result.valid || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      width_r <= result.total_width;
    end
  end

  assign out_valid = valid_r;
  assign out_total_width = width_r;

endmodule

/* design/utf8dw_checker.sv */
// Port-level assertions for utf8_display_width and the bind that attaches them.
module utf8dw_checker
  import utf8dw_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [BYTE_W-1:0] in_text_byte,
  input logic              in_end_of_text,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OUT_W-1:0]  out_total_width
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_width))
    else $error("stalled result transaction changed");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("valid or stall set after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_free_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register was free");

endmodule

bind utf8_display_width utf8dw_checker u_chk (.*);

/* tb/utf8dw_check_pkg.sv */
// Column-width tables and the string-width scoreboard for the utf8_display_width testbench.
package utf8dw_check_pkg;

  typedef struct packed {
    logic [20:0] first_cp;
    logic [20:0] last_cp;
  } span_t;

  localparam int N_COMBINING = 42;
  localparam int N_DOUBLE = 16;

  localparam span_t COMBINING_SPANS [N_COMBINING] = '{
    '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00489}, '{21'h00591, 21'h005BD},
    '{21'h005BF, 21'h005BF}, '{21'h005C1, 21'h005C2}, '{21'h005C4, 21'h005C5},
    '{21'h005C7, 21'h005C7}, '{21'h00610, 21'h0061A}, '{21'h0064B, 21'h0065F},
    '{21'h00670, 21'h00670}, '{21'h006D6, 21'h006DC}, '{21'h006DF, 21'h006E4},
    '{21'h006E7, 21'h006E8}, '{21'h006EA, 21'h006ED}, '{21'h00711, 21'h00711},
    '{21'h00730, 21'h0074A}, '{21'h007A6, 21'h007B0}, '{21'h00816, 21'h00819},
    '{21'h0081B, 21'h00823}, '{21'h00825, 21'h00827}, '{21'h00829, 21'h0082D},
    '{21'h00859, 21'h0085B}, '{21'h00E31, 21'h00E31}, '{21'h00E34, 21'h00E3A},
    '{21'h00E47, 21'h00E4E}, '{21'h00EB1, 21'h00EB1}, '{21'h00EB4, 21'h00EB9},
    '{21'h00EBB, 21'h00EBC}, '{21'h00EC8, 21'h00ECD}, '{21'h0180B, 21'h0180D},
    '{21'h01AB0, 21'h01AFF}, '{21'h01DC0, 21'h01DFF}, '{21'h0200B, 21'h0200F},
    '{21'h0202A, 21'h0202E}, '{21'h02060, 21'h02064}, '{21'h02066, 21'h0206F},
    '{21'h020D0, 21'h020FF}, '{21'h0302A, 21'h0302F}, '{21'h0FE00, 21'h0FE0F},
    '{21'h0FE20, 21'h0FE2F}, '{21'h0FEFF, 21'h0FEFF}, '{21'hE0100, 21'hE01EF}
  };

  localparam span_t DOUBLE_SPANS [N_DOUBLE] = '{
    '{21'h01100, 21'h0115F}, '{21'h02E80, 21'h0303E}, '{21'h03041, 21'h033FF},
    '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF}, '{21'h0A000, 21'h0A4CF},
    '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF}, '{21'h0FE30, 21'h0FE4F},
    '{21'h0FF00, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6}, '{21'h1F300, 21'h1F64F},
    '{21'h1F680, 21'h1F6FF}, '{21'h1F900, 21'h1F9FF}, '{21'h20000, 21'h2FFFD},
    '{21'h30000, 21'h3FFFD}
  };

  class width_scoreboard;
    logic [20:0] cp_acc;
    logic [1:0]  cont_needed;
    logic [1:0]  cont_held;
    logic [31:0] columns;
    logic [31:0] totals_q[$];
    int unsigned fails;

    function new();
      clear();
      fails = 0;
    endfunction

    function void clear();
      cp_acc = '0;
      cont_needed = '0;
      cont_held = '0;
      columns = '0;
    endfunction

    function logic [1:0] glyph_cols(logic [20:0] cp);
      if (cp < 21'h20 || cp == 21'h7F) return 2'd0;
      if (cp >= 21'h80 && cp <= 21'h9F) return 2'd0;
      if (cp >= 21'hD800 && cp <= 21'hDFFF) return 2'd0;
      foreach (COMBINING_SPANS[i]) begin
        if (cp >= COMBINING_SPANS[i].first_cp && cp <= COMBINING_SPANS[i].last_cp) return 2'd0;
      end
      foreach (DOUBLE_SPANS[i]) begin
        if (cp >= DOUBLE_SPANS[i].first_cp && cp <= DOUBLE_SPANS[i].last_cp) return 2'd2;
      end
      return 2'd1;
    endfunction

    function void add_columns(logic [31:0] n);
      if (columns > 32'hFFFF_FFFF - n) columns = 32'hFFFF_FFFF;
      else columns = columns + n;
    endfunction

    function void open_lead(logic [7:0] b);
      if (b[7] == 1'b0) begin
        add_columns({30'd0, glyph_cols({13'd0, b})});
      end else if (b[7:5] == 3'b110) begin
        cp_acc = {16'd0, b[4:0]};
        cont_needed = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = {17'd0, b[3:0]};
        cont_needed = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = {18'd0, b[2:0]};
        cont_needed = 2'd3;
      end else begin
        add_columns(32'd1);
      end
      cont_held = 2'd0;
    endfunction

    function void note_byte(logic [7:0] b, logic eot);
      if (cont_needed != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          cp_acc = {cp_acc[14:0], b[5:0]};
          cont_held = cont_held + 2'd1;
          cont_needed = cont_needed - 2'd1;
          if (cont_needed == 2'd0) begin
            add_columns({30'd0, glyph_cols(cp_acc)});
            cont_held = 2'd0;
          end
        end else begin
          // count the broken sequence, then reuse the byte as a lead
          add_columns(32'd1 + {30'd0, cont_held});
          cont_needed = 2'd0;
          cont_held = 2'd0;
          open_lead(b);
        end
      end else begin
        open_lead(b);
      end
      if (eot) begin
        if (cont_needed != 2'd0) add_columns(32'd1 + {30'd0, cont_held});
        totals_q.push_back(columns);
        clear();
      end
    endfunction

    function void check_total(logic [31:0] actual);
      logic [31:0] want;
      if (totals_q.size() == 0) begin
        $display("ERROR %0t: total expected none actual %0d", $time, actual);
        fails++;
        return;
      end
      want = totals_q.pop_front();
      if (actual !== want) begin
        $display("ERROR %0t: total expected %0d actual %0d", $time, want, actual);
        fails++;
      end
    endfunction

    function int pending();
      return totals_q.size();
    endfunction
  endclass

endpackage

/* tb/utf8_display_width_tb.sv */
// Top-level testbench for utf8_display_width: directed and random UTF-8 strings checked by total.
module utf8_display_width_tb;
  import utf8dw_pkg::*;
  import utf8dw_check_pkg::*;

  localparam int RANDOM_BYTES = 1500;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_text_byte = '0;
  logic              in_end_of_text = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  out_total_width;

  width_scoreboard sb;
  item_t           text_q[$];
  int              bytes_sent = 0;
  int              in_idle_pct = 36;
  int              stall_pct = 80;

  utf8_display_width dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_total_width(out_total_width)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_total(out_total_width);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int shortest_len(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [20:0] pick_codepoint();
    int    roll;
    span_t sp;
    roll = $urandom_range(99);
    if (roll < 30) return 21'($urandom_range(21'h7F));
    if (roll < 45) return 21'($urandom_range(21'h7FF, 21'h80));
    if (roll < 60) return 21'($urandom_range(21'hFFFF, 21'h800));
    if (roll < 70) return 21'($urandom_range(21'h1FFFFF, 21'h10000));
    if (roll < 95) begin
      if ($urandom_range(1)) sp = COMBINING_SPANS[$urandom_range(N_COMBINING - 1)];
      else sp = DOUBLE_SPANS[$urandom_range(N_DOUBLE - 1)];
      case ($urandom_range(4))
        0: return sp.first_cp - 21'd1;
        1: return sp.first_cp;
        2: return sp.last_cp;
        3: return sp.last_cp + 21'd1;
        default: return sp.first_cp + 21'($urandom_range(sp.last_cp - sp.first_cp));
      endcase
    end
    case ($urandom_range(9))
      0: return 21'h1F;
      1: return 21'h20;
      2: return 21'h7E;
      3: return 21'h7F;
      4: return 21'h9F;
      5: return 21'hA0;
      6: return 21'hD7FF;
      7: return 21'hD800;
      8: return 21'hDFFF;
      default: return 21'hE000;
    endcase
  endfunction

  task automatic add_glyph(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] enc [4];
    enc = '{default: 8'h00};
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) text_q.push_back('{text_byte: enc[i], end_of_text: 1'b0});
  endtask

  task automatic make_string();
    int          glyphs;
    int          roll;
    int          len;
    logic [20:0] cp;
    glyphs = $urandom_range(6, 1);
    for (int g = 0; g < glyphs; g++) begin
      roll = $urandom_range(99);
      cp = pick_codepoint();
      len = shortest_len(cp);
      if (roll < 80) begin
        if ($urandom_range(19) == 0 && len < 4) len = $urandom_range(4, len + 1);
        add_glyph(cp, len, len);
      end else if (roll < 90) begin
        if (len == 1) len = $urandom_range(4, 2);
        add_glyph(cp, len, $urandom_range(len - 1, 1));
      end else begin
        text_q.push_back('{text_byte: 8'($urandom), end_of_text: 1'b0});
      end
    end
    text_q[text_q.size() - 1].end_of_text = 1'b1;
  endtask

  task automatic send_text();
    item_t it;
    while (text_q.size() != 0) begin
      it = text_q.pop_front();
      if ($urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
      end
      in_valid <= 1'b1;
      in_text_byte <= it.text_byte;
      in_end_of_text <= it.end_of_text;
      do @(posedge clk); while (in_stall);
      sb.note_byte(it.text_byte, it.end_of_text);
      bytes_sent++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    logic [8:0] script[$];
    int         directed_bytes;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // bit 8 marks the last byte of a string
    script = '{9'h041, 9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0CC, 9'h080, 9'h0E4, 9'h0B8, 9'h180,
               9'h0C0, 9'h081, 9'h0ED, 9'h0A0, 9'h080, 9'h0F0, 9'h09F, 9'h08C, 9'h180,
               9'h080, 9'h0FF, 9'h0F8, 9'h0E4, 9'h0B8, 9'h141,
               9'h0F7, 9'h0BF, 9'h1BF};
    foreach (script[i]) text_q.push_back('{text_byte: script[i][7:0], end_of_text: script[i][8]});
    send_text();
    drain_results();
    directed_bytes = bytes_sent;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 36;
          stall_pct = 80;
        end
        1: begin
          in_idle_pct = 80;
          stall_pct = 36;
        end
        default: begin
          in_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      while (bytes_sent < directed_bytes + RANDOM_BYTES * (ph + 1) / 3) begin
        make_string();
        send_text();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("utf8_display_width regression: pass");
    end else begin
      $display("utf8_display_width regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("utf8_display_width regression: fail");
    $finish;
  end

endmodule
